/* rtl/core/vqncs_pkg.sv */
// Shared types and constants for the nearest-codeword search block.
// No dependencies; imported by the datapath, the top level and the checker.
package vqncs_pkg;

   // Field widths fixed by the interface
   localparam int OP_W       = 1;
   localparam int CW_IDX_W   = 8;
   localparam int ELEM_W     = 4;
   localparam int DIMS_CFG_W = 5;
   localparam int NCW_CFG_W  = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODEWORDS = 1'b1;

   // Register reset values
   localparam logic [DIMS_CFG_W-1:0] DIMS_RESET = 5'd16;
   localparam logic [NCW_CFG_W-1:0]  NCW_RESET  = 9'd256;

   // Control from the sequencer to the distance pipeline
   typedef struct packed {
      logic start;      // clear accumulator and best-so-far
      logic issue;      // a codebook/query read pair was issued this cycle
      logic elem_last;  // issued read is the last element of its codeword
   } vqncs_ctl_type;

endpackage

/* rtl/core/vqncs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vqncs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/vqncs_datapath.sv */
// Distance pipeline: difference, square, per-codeword accumulate, best-so-far compare.
// Depends on vqncs_pkg; fed by the two RAM read ports under control of the top level.
module vqncs_datapath #(
   parameter int MAX_DIMS      = 16,
   parameter int MAX_CODEWORDS = 256,
   parameter int SAMPLE_WIDTH  = 16,
   localparam int CW_W         = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vqncs_pkg::vqncs_ctl_type       ctl,
   input  logic [CW_W-1:0]                issue_cw,
   input  logic signed [SAMPLE_WIDTH-1:0] cb_data,
   input  logic signed [SAMPLE_WIDTH-1:0] q_data,
   output logic                           busy,
   output logic [CW_W-1:0]                best_cw
);
   import vqncs_pkg::*;

   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int SQ_W   = 2 * SAMPLE_WIDTH;
   localparam int ACC_W  = SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1) + 1;

   // stage 1: RAM data valid
   logic                     s1_valid_ff, s1_last_ff;
   logic [CW_W-1:0]          s1_cw_ff;
   // stage 2: difference
   logic                     s2_valid_ff, s2_last_ff;
   logic [CW_W-1:0]          s2_cw_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   // stage 3: square
   logic                     s3_valid_ff, s3_last_ff;
   logic [CW_W-1:0]          s3_cw_ff;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic signed [2*DIFF_W-1:0] prod;
   // stage 4: accumulate, then compare
   logic [ACC_W-1:0]         acc_ff, sum;
   logic                     tot_valid_ff;
   logic [ACC_W-1:0]         total_ff;
   logic [CW_W-1:0]          tot_cw_ff;
   logic [ACC_W-1:0]         best_dist_ff;
   logic [CW_W-1:0]          best_cw_ff;

   assign diff_in = DIFF_W'(q_data) - DIFF_W'(cb_data);
   assign prod    = diff_ff * diff_ff;
   assign sq_in   = prod[SQ_W-1:0];   // |diff| < 2**SAMPLE_WIDTH, so the square fits
   assign sum     = acc_ff + ACC_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         tot_valid_ff <= 1'b0;
         acc_ff       <= '0;
         best_dist_ff <= '1;
         best_cw_ff   <= '0;
      end else begin
         s1_valid_ff  <= ctl.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         tot_valid_ff <= s3_valid_ff && s3_last_ff;

         if (ctl.start) begin
            acc_ff <= '0;
         end else if (s3_valid_ff) begin
            acc_ff <= s3_last_ff ? '0 : sum;
         end

         if (ctl.start) begin
            best_dist_ff <= '1;
            best_cw_ff   <= '0;
         end else if (tot_valid_ff && (total_ff < best_dist_ff)) begin
            // strict less-than: earlier codeword wins a tie
            best_dist_ff <= total_ff;
            best_cw_ff   <= tot_cw_ff;
         end
      end
   end

   // payload of the pipeline, no reset
   always_ff @(posedge clock) begin
      s1_last_ff <= ctl.elem_last;
      s1_cw_ff   <= issue_cw;
      s2_last_ff <= s1_last_ff;
      s2_cw_ff   <= s1_cw_ff;
      diff_ff    <= diff_in;
      s3_last_ff <= s2_last_ff;
      s3_cw_ff   <= s2_cw_ff;
      sq_ff      <= sq_in;
      total_ff   <= sum;
      tot_cw_ff  <= s3_cw_ff;
   end

   assign busy    = s1_valid_ff || s2_valid_ff || s3_valid_ff || tot_valid_ff;
   assign best_cw = best_cw_ff;

endmodule

/* rtl/core/vq_nearest_codeword_search.sv */
// Top level of the vector-quantizer nearest-codeword search.
// Depends on vqncs_pkg, vqncs_ram (codebook and query buffer) and vqncs_datapath.
//
// Loads and query elements that do not complete a vector are taken whenever req_ready is high.
// The query element at position dims_in_use-1 starts a search that reads one codebook
// element per cycle through the single codebook read port and one multiply-accumulate,
// and waits for the distance pipeline to drain. The chosen codeword then streams out one
// element at a time, each read and then loaded into the output register once it is free,
// dims_in_use results with the last marked. req_ready is low from the start of a search
// until the final result sits in the output register; a new item is taken while that
// result still waits. No clearing pass is needed.
module vq_nearest_codeword_search #(
   parameter int MAX_DIMS      = 16,
   parameter int MAX_CODEWORDS = 256,
   parameter int SAMPLE_WIDTH  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [vqncs_pkg::OP_W-1:0]           req_operation,
   input  logic [vqncs_pkg::CW_IDX_W-1:0]       req_codeword_index,
   input  logic [vqncs_pkg::ELEM_W-1:0]         req_element_index,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_value,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vqncs_pkg::CW_IDX_W-1:0]       rsp_best_index,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_quantized_value,
   output logic [vqncs_pkg::ELEM_W-1:0]         rsp_position,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [vqncs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vqncs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import vqncs_pkg::*;

   localparam int DIM_AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CW_W     = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
   localparam int DCNT_W   = ($clog2(MAX_DIMS + 1) > DIMS_CFG_W) ?
                             $clog2(MAX_DIMS + 1) : DIMS_CFG_W;
   localparam int KCNT_W   = ($clog2(MAX_CODEWORDS + 1) > NCW_CFG_W) ?
                             $clog2(MAX_CODEWORDS + 1) : NCW_CFG_W;
   localparam int CB_DEPTH = MAX_CODEWORDS * (1 << DIM_AW);
   localparam int CB_AW    = CW_W + DIM_AW;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT_WR = 3'd4;

   logic [DIMS_CFG_W-1:0] dims_cfg_ff;
   logic [NCW_CFG_W-1:0]  ncw_cfg_ff;

   logic [DCNT_W-1:0] dims_ext, dims_eff, dims_last_ext, el_ext;
   logic [KCNT_W-1:0] ncw_ext, ncw_eff, ncw_last_ext;
   logic [DIM_AW-1:0] dims_last;
   logic [CW_W-1:0]   ncw_last;

   logic accept, el_ok, cw_ok, cb_we, q_we, trigger;

   logic [2:0]        state_ff, state_in;
   logic [CW_W-1:0]   k_ff, k_in;
   logic [DIM_AW-1:0] j_ff, j_in;
   logic              issue, load, out_free, j_at_last;

   logic [CB_AW-1:0]              cb_wr_addr, cb_rd_addr;
   logic signed [SAMPLE_WIDTH-1:0] cb_rd_data, q_rd_data;

   vqncs_ctl_type   ctl;
   logic            dp_busy;
   logic [CW_W-1:0] best_cw;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CW_IDX_W-1:0]            rsp_best_index_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic [ELEM_W-1:0]              rsp_position_ff;
   logic                           rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_cfg_ff <= DIMS_RESET;
         ncw_cfg_ff  <= NCW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIMS:      dims_cfg_ff <= csr_wdata[DIMS_CFG_W-1:0];
            CSR_CODEWORDS: ncw_cfg_ff  <= csr_wdata[NCW_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // registers saturate into 1..MAX when used
   always_comb begin
      dims_ext = DCNT_W'(dims_cfg_ff);
      if (dims_ext == '0)                          dims_eff = DCNT_W'(1);
      else if (dims_ext > DCNT_W'(MAX_DIMS))       dims_eff = DCNT_W'(MAX_DIMS);
      else                                         dims_eff = dims_ext;
      ncw_ext = KCNT_W'(ncw_cfg_ff);
      if (ncw_ext == '0)                           ncw_eff = KCNT_W'(1);
      else if (ncw_ext > KCNT_W'(MAX_CODEWORDS))   ncw_eff = KCNT_W'(MAX_CODEWORDS);
      else                                         ncw_eff = ncw_ext;
   end

   assign dims_last_ext = dims_eff - DCNT_W'(1);
   assign ncw_last_ext  = ncw_eff - KCNT_W'(1);
   assign dims_last     = DIM_AW'(dims_last_ext);
   assign ncw_last      = CW_W'(ncw_last_ext);

   // input decode
   assign accept  = req_valid && req_ready;
   assign el_ext  = DCNT_W'(req_element_index);
   assign el_ok   = el_ext < DCNT_W'(MAX_DIMS);
   assign cw_ok   = KCNT_W'(req_codeword_index) < KCNT_W'(MAX_CODEWORDS);
   assign cb_we   = accept && (req_operation == OP_LOAD) && el_ok && cw_ok;
   assign q_we    = accept && (req_operation == OP_QUERY) && el_ok;
   assign trigger = q_we && (el_ext == dims_last_ext);

   assign cb_wr_addr = {CW_W'(req_codeword_index), DIM_AW'(req_element_index)};
   assign cb_rd_addr = (state_ff == ST_SEARCH) ? {k_ff, j_ff} : {best_cw, j_ff};

   vqncs_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (CB_DEPTH)
   ) u_codebook (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (cb_wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (cb_rd_addr),
      .rd_data (cb_rd_data)
   );

   vqncs_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_DIMS)
   ) u_query (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (DIM_AW'(req_element_index)),
      .wr_data (req_sample_value),
      .rd_addr (j_ff),
      .rd_data (q_rd_data)
   );

   // sequencer
   assign j_at_last = (j_ff == dims_last);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      issue    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (trigger) begin
               state_in = ST_SEARCH;
               k_in     = '0;
               j_in     = '0;
            end
         end
         ST_SEARCH: begin
            issue = 1'b1;
            if (j_at_last) begin
               j_in = '0;
               if (k_ff == ncw_last) state_in = ST_DRAIN;
               else                  k_in     = k_ff + CW_W'(1);
            end else begin
               j_in = j_ff + DIM_AW'(1);
            end
         end
         ST_DRAIN: begin
            // compare of the final codeword has landed once the pipeline is empty
            if (!dp_busy) begin
               state_in = ST_EMIT_RD;
               j_in     = '0;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            // read address is held, so the RAM output stays valid while stalled
            if (out_free) begin
               load = 1'b1;
               if (j_at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + DIM_AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   assign ctl.start     = trigger;
   assign ctl.issue     = issue;
   assign ctl.elem_last = j_at_last;

   vqncs_datapath #(
      .MAX_DIMS      (MAX_DIMS),
      .MAX_CODEWORDS (MAX_CODEWORDS),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .issue_cw (k_ff),
      .cb_data  (cb_rd_data),
      .q_data   (q_rd_data),
      .busy     (dp_busy),
      .best_cw  (best_cw)
   );

   // output register
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_best_index_ff <= CW_IDX_W'(best_cw);
         rsp_value_ff      <= cb_rd_data;
         rsp_position_ff   <= ELEM_W'(j_ff);
         rsp_last_ff       <= j_at_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_index      = rsp_best_index_ff;
   assign rsp_quantized_value = rsp_value_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

/* rtl/core/vqncs_checker.sv */
// Port-level checks for vq_nearest_codeword_search, attached by bind.
// Depends on vqncs_pkg and the top level's port list.
module vqncs_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [vqncs_pkg::OP_W-1:0]       req_operation,
   input logic [vqncs_pkg::CW_IDX_W-1:0]   req_codeword_index,
   input logic [vqncs_pkg::ELEM_W-1:0]     req_element_index,
   input logic signed [SAMPLE_WIDTH-1:0]   req_sample_value,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [vqncs_pkg::CW_IDX_W-1:0]   rsp_best_index,
   input logic signed [SAMPLE_WIDTH-1:0]   rsp_quantized_value,
   input logic [vqncs_pkg::ELEM_W-1:0]     rsp_position,
   input logic                             rsp_last,
   input logic                             csr_wr_en,
   input logic [vqncs_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [vqncs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vqncs_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_index)
         && $stable(rsp_quantized_value) && $stable(rsp_position) && $stable(rsp_last))
      else $error("stalled result changed");

   // input is closed while a codeword is still streaming out
   a_no_input_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input open in the middle of a result burst");

   // a load transfer never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("result after a load");

endmodule

bind vq_nearest_codeword_search vqncs_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_vqncs_checker (.*);
